// File: rtl/detection_candidate_decode_defines.svh
// ----------------------------------------------------------------------------
// detection_candidate_decode assertion macros
// Shared assertion shorthands for the decode block checker.
// ----------------------------------------------------------------------------
`ifndef DETECTION_CANDIDATE_DECODE_DEFINES_SVH
`define DETECTION_CANDIDATE_DECODE_DEFINES_SVH

// clocked assertion, quiet while reset is high
`define DCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define DCD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/dcd_pkg.sv
// ----------------------------------------------------------------------------
// dcd_pkg
// Types and constants shared by the detection candidate decode modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dcd_pkg;

  localparam int SCORE_W  = 16;
  localparam int COORD_W  = 16;
  localparam int SCALE_W  = 16;
  localparam int PIX_W    = 12;
  localparam int CLASS_W  = 7;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 88;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // register index codes (byte address = 4 * index)
  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_SCALE_X   = 3'd1;
  localparam logic [2:0] REG_SCALE_Y   = 3'd2;
  localparam logic [2:0] REG_IMG_W     = 3'd3;
  localparam logic [2:0] REG_IMG_H     = 3'd4;

  localparam logic [SCORE_W-1:0] THRESHOLD_RST = 16'd16384;
  localparam logic [SCALE_W-1:0] SCALE_RST     = 16'd4096;
  localparam logic [PIX_W-1:0]   IMG_W_RST     = 12'd1920;
  localparam logic [PIX_W-1:0]   IMG_H_RST     = 12'd1080;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // one kept candidate, handed from front to back
  typedef struct packed {
    logic [CLASS_W-1:0] class_id;
    logic [SCORE_W-1:0] confidence;
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [COORD_W-1:0] box_w;
    logic [COORD_W-1:0] box_h;
  } job_t;

  typedef struct packed {
    logic [CLASS_W-1:0] class_id;
    logic [SCORE_W-1:0] confidence;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] out_width;
    logic [COORD_W-1:0] out_height;
  } result_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score_threshold;
    logic [SCALE_W-1:0] scale_x;
    logic [SCALE_W-1:0] scale_y;
    logic [PIX_W-1:0]   image_width;
    logic [PIX_W-1:0]   image_height;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/detection_candidate_decode.sv
// ----------------------------------------------------------------------------
// detection_candidate_decode
// Class score stream to thresholded, scaled corner-form detection boxes.
// ----------------------------------------------------------------------------
// One score word is taken per clock. s_tready drops only while the four-entry
// candidate queue is full, which happens only if more than four kept
// candidates finish while m_tready is held low. Each kept candidate passes
// through the queue and then the box pipeline registers (subtract, multiply,
// saturate, edge limit + output register) to reach m_tdata; the box pipeline
// takes one candidate per clock unless a stalled output word holds it.
// Registers are read live, so write them only while the block is idle.
`default_nettype none

module detection_candidate_decode #(
  parameter int MAX_CLASSES = 128
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // slave stream
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // center_x, center_y, box_w, box_h, class_score
  input  wire logic [dcd_pkg::IN_DATA_W-1:0]     s_tdata,
  input  wire logic                              s_tlast,
  // master stream
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // class_id, confidence, left, top, out_width, out_height, zero pad
  output logic [dcd_pkg::OUT_DATA_W-1:0]         m_tdata,
  // config port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [dcd_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [dcd_pkg::DATA_W-1:0]        pwdata,
  output logic [dcd_pkg::DATA_W-1:0]             prdata,
  output logic                                   pready
);

  dcd_pkg::cfg_t    cfg;
  dcd_pkg::job_t    push_job, pop_job;
  dcd_pkg::result_t res;
  logic             push, queue_full, queue_valid, pop;
  logic             wr_en;
  logic [2:0]       reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.score_threshold <= dcd_pkg::THRESHOLD_RST;
      cfg.scale_x         <= dcd_pkg::SCALE_RST;
      cfg.scale_y         <= dcd_pkg::SCALE_RST;
      cfg.image_width     <= dcd_pkg::IMG_W_RST;
      cfg.image_height    <= dcd_pkg::IMG_H_RST;
    end else if (wr_en) begin
      case (reg_idx)
        dcd_pkg::REG_THRESHOLD: cfg.score_threshold <= pwdata[15:0];
        dcd_pkg::REG_SCALE_X:   cfg.scale_x         <= pwdata[15:0];
        dcd_pkg::REG_SCALE_Y:   cfg.scale_y         <= pwdata[15:0];
        dcd_pkg::REG_IMG_W:     cfg.image_width     <= pwdata[11:0];
        dcd_pkg::REG_IMG_H:     cfg.image_height    <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dcd_pkg::REG_THRESHOLD: prdata = 32'(cfg.score_threshold);
      dcd_pkg::REG_SCALE_X:   prdata = 32'(cfg.scale_x);
      dcd_pkg::REG_SCALE_Y:   prdata = 32'(cfg.scale_y);
      dcd_pkg::REG_IMG_W:     prdata = 32'(cfg.image_width);
      dcd_pkg::REG_IMG_H:     prdata = 32'(cfg.image_height);
      default:                prdata = '0;
    endcase
  end

  dcd_front #(
    .MAX_CLASSES(MAX_CLASSES)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .center_x       (s_tdata[15:0]),
    .center_y       (s_tdata[31:16]),
    .box_w          (s_tdata[47:32]),
    .box_h          (s_tdata[63:48]),
    .class_score    (s_tdata[79:64]),
    .last_score     (s_tlast),
    .score_threshold(cfg.score_threshold),
    .queue_full     (queue_full),
    .push           (push),
    .push_job       (push_job)
  );

  dcd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (queue_full),
    .not_empty(queue_valid),
    .pop      (pop),
    .pop_job  (pop_job)
  );

  dcd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .job_valid(queue_valid),
    .job_pop  (pop),
    .job      (pop_job),
    .res_valid(m_tvalid),
    .res_ready(m_tready),
    .res      (res)
  );

  assign m_tdata = {1'b0, res.out_height, res.out_width, res.top, res.left,
                    res.confidence, res.class_id};

endmodule

`default_nettype wire

// File: rtl/dcd_front.sv
// ----------------------------------------------------------------------------
// dcd_front
// Running best-class compare over a score stream; queues kept candidates.
// ----------------------------------------------------------------------------
`default_nettype none

module dcd_front #(
  parameter int MAX_CLASSES = 128
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [dcd_pkg::COORD_W-1:0]   center_x,
  input  wire logic [dcd_pkg::COORD_W-1:0]   center_y,
  input  wire logic [dcd_pkg::COORD_W-1:0]   box_w,
  input  wire logic [dcd_pkg::COORD_W-1:0]   box_h,
  input  wire logic [dcd_pkg::SCORE_W-1:0]   class_score,
  input  wire logic                          last_score,
  input  wire logic [dcd_pkg::SCORE_W-1:0]   score_threshold,
  input  wire logic                          queue_full,
  output logic                               push,
  output dcd_pkg::job_t                      push_job
);

  localparam logic [dcd_pkg::CLASS_W-1:0] CLASS_LIMIT = dcd_pkg::CLASS_W'(MAX_CLASSES - 1);

  logic [dcd_pkg::SCORE_W-1:0] best_score;
  logic [dcd_pkg::CLASS_W-1:0] best_class;
  logic [dcd_pkg::CLASS_W-1:0] class_counter;

  logic                        take;
  logic                        win;
  logic [dcd_pkg::SCORE_W-1:0] cur_score;
  logic [dcd_pkg::CLASS_W-1:0] cur_class;

  assign in_ready  = !queue_full;
  assign take      = in_valid && in_ready;
  assign win       = class_score > best_score;
  assign cur_score = win ? class_score : best_score;
  assign cur_class = win ? class_counter : best_class;

  assign push = take && last_score && (cur_score >= score_threshold);

  always_comb begin
    push_job.class_id   = cur_class;
    push_job.confidence = cur_score;
    push_job.center_x   = center_x;
    push_job.center_y   = center_y;
    push_job.box_w      = box_w;
    push_job.box_h      = box_h;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_score    <= '0;
      best_class    <= '0;
      class_counter <= '0;
    end else if (take) begin
      if (last_score) begin
        best_score    <= '0;
        best_class    <= '0;
        class_counter <= '0;
      end else begin
        best_score <= cur_score;
        best_class <= cur_class;
        // index sticks at the top class once the limit is reached
        if (class_counter < CLASS_LIMIT) begin
          class_counter <= class_counter + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/dcd_queue.sv
// ----------------------------------------------------------------------------
// dcd_queue
// Small register FIFO between the score front end and the box back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dcd_queue (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire dcd_pkg::job_t push_job,
  output logic         full,
  output logic         not_empty,
  input  wire logic    pop,
  output dcd_pkg::job_t pop_job
);

  dcd_pkg::job_t               entries [dcd_pkg::QUEUE_DEPTH];
  logic [dcd_pkg::QPTR_W-1:0]  wr_ptr;
  logic [dcd_pkg::QPTR_W-1:0]  rd_ptr;
  logic [dcd_pkg::QPTR_W:0]    count;

  assign full      = count == (dcd_pkg::QPTR_W+1)'(dcd_pkg::QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign pop_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/dcd_back.sv
// ----------------------------------------------------------------------------
// dcd_back
// Box pipeline: center to corner form, scaling, clamping, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dcd_back (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire dcd_pkg::cfg_t cfg,
  input  wire logic     job_valid,
  output logic          job_pop,
  input  wire dcd_pkg::job_t job,
  output logic          res_valid,
  input  wire logic     res_ready,
  output dcd_pkg::result_t res
);

  // stage 1: 2*center - size
  logic          v1;
  logic          s1_pos_x, s1_pos_y;
  logic [16:0]   s1_dx, s1_dy;
  dcd_pkg::job_t s1_job;

  // stage 2: products
  logic          v2;
  logic [32:0]   s2_px, s2_py;
  logic [31:0]   s2_pw, s2_ph;
  logic [dcd_pkg::CLASS_W-1:0] s2_class;
  logic [dcd_pkg::SCORE_W-1:0] s2_conf;

  // stage 3: saturated corner and size
  logic          v3;
  logic [15:0]   s3_left, s3_top, s3_sw, s3_sh;
  logic [dcd_pkg::CLASS_W-1:0] s3_class;
  logic [dcd_pkg::SCORE_W-1:0] s3_conf;

  logic          adv;
  logic [16:0]   tw_x, tw_y;
  logic [15:0]   edge_x, edge_y, room_x, room_y;

  // whole pipeline steps together; the queue in front soaks up stalls
  assign adv     = !res_valid || res_ready;
  assign job_pop = adv && job_valid;

  assign tw_x = {job.center_x, 1'b0};
  assign tw_y = {job.center_y, 1'b0};

  assign edge_x = {cfg.image_width, 4'h0};
  assign edge_y = {cfg.image_height, 4'h0};
  assign room_x = (s3_left >= edge_x) ? 16'd0 : edge_x - s3_left;
  assign room_y = (s3_top  >= edge_y) ? 16'd0 : edge_y - s3_top;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_job   <= job;
      s1_pos_x <= tw_x > {1'b0, job.box_w};
      s1_pos_y <= tw_y > {1'b0, job.box_h};
      s1_dx    <= tw_x - {1'b0, job.box_w};
      s1_dy    <= tw_y - {1'b0, job.box_h};

      s2_px    <= s1_pos_x ? 33'(s1_dx) * 33'(cfg.scale_x) : 33'd0;
      s2_py    <= s1_pos_y ? 33'(s1_dy) * 33'(cfg.scale_y) : 33'd0;
      s2_pw    <= 32'(s1_job.box_w) * 32'(cfg.scale_x);
      s2_ph    <= 32'(s1_job.box_h) * 32'(cfg.scale_y);
      s2_class <= s1_job.class_id;
      s2_conf  <= s1_job.confidence;

      // corner is in 2^-17 units, size in 2^-16; both floor to Q12.4
      s3_left  <= (|s2_px[32:29]) ? 16'hFFFF : s2_px[28:13];
      s3_top   <= (|s2_py[32:29]) ? 16'hFFFF : s2_py[28:13];
      s3_sw    <= (|s2_pw[31:28]) ? 16'hFFFF : s2_pw[27:12];
      s3_sh    <= (|s2_ph[31:28]) ? 16'hFFFF : s2_ph[27:12];
      s3_class <= s2_class;
      s3_conf  <= s2_conf;

      res.class_id   <= s3_class;
      res.confidence <= s3_conf;
      res.left       <= s3_left;
      res.top        <= s3_top;
      res.out_width  <= (s3_sw < room_x) ? s3_sw : room_x;
      res.out_height <= (s3_sh < room_y) ? s3_sh : room_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      v1        <= job_valid;
      v2        <= v1;
      v3        <= v2;
      res_valid <= v3;
    end
  end

endmodule

`default_nettype wire

// File: rtl/dcd_checker.sv
// ----------------------------------------------------------------------------
// dcd_checker
// Port-level checks for detection_candidate_decode, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "detection_candidate_decode_defines.svh"

module dcd_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tvalid,
  input wire logic                          s_tready,
  input wire logic [dcd_pkg::IN_DATA_W-1:0] s_tdata,
  input wire logic                          s_tlast,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [dcd_pkg::OUT_DATA_W-1:0] m_tdata,
  input wire logic                          psel,
  input wire logic                          penable,
  input wire logic                          pwrite,
  input wire logic [dcd_pkg::ADDR_W-1:0]    paddr,
  input wire logic [dcd_pkg::DATA_W-1:0]    pwdata,
  input wire logic [dcd_pkg::DATA_W-1:0]    prdata,
  input wire logic                          pready
);

  // a stalled output word holds
  `DCD_ASSERT(a_out_hold,
              m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata),
              "output word changed while stalled")

  // pipeline empties on reset
  `DCD_ASSERT_RST(a_rst_empty, rst |=> !m_tvalid, "output valid right after reset")

  // a nonzero class only wins with a strictly positive score
  `DCD_ASSERT(a_class_conf,
              m_tvalid |-> (m_tdata[6:0] == 7'd0 || m_tdata[22:7] != 16'd0),
              "class set with zero confidence")

  // threshold register reads back what was written
  `DCD_ASSERT(a_thr_readback,
              psel && penable && pwrite && pready &&
              paddr[4:2] == dcd_pkg::REG_THRESHOLD |=>
              (paddr[4:2] != dcd_pkg::REG_THRESHOLD ||
               prdata[15:0] == $past(pwdata[15:0])),
              "threshold readback mismatch")

endmodule

bind detection_candidate_decode dcd_checker u_dcd_checker (.*);

`default_nettype wire
